FILE: rtl/core/eab_pkg.sv
// Package with shared constants and arithmetic helpers for the Euler-angle basis block.
`default_nettype none
package eab_pkg;

   localparam int ANGLE_W = 18;
   localparam int OUT_W = 16;
   localparam int Z_W = 33;
   localparam int V_W = 32;
   localparam int DEG_FRAC = 24;
   localparam int VEC_FRAC = 30;
   localparam int ATAN_COUNT = 24;
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_ANGLE_FRAC_BITS = 8;
   localparam int DEF_OUT_FRAC_BITS = 15;
   localparam logic signed [V_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;

   function automatic logic signed [Z_W-1:0] atan_deg(int idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         0: a = 33'sd754974720;
         1: a = 33'sd445687602;
         2: a = 33'sd235489088;
         3: a = 33'sd119537938;
         4: a = 33'sd60000934;
         5: a = 33'sd30029717;
         6: a = 33'sd15018523;
         7: a = 33'sd7509720;
         8: a = 33'sd3754917;
         9: a = 33'sd1877466;
         10: a = 33'sd938734;
         11: a = 33'sd469367;
         12: a = 33'sd234684;
         13: a = 33'sd117342;
         14: a = 33'sd58671;
         15: a = 33'sd29335;
         16: a = 33'sd14668;
         17: a = 33'sd7334;
         18: a = 33'sd3667;
         19: a = 33'sd1833;
         20: a = 33'sd917;
         21: a = 33'sd458;
         22: a = 33'sd229;
         23: a = 33'sd115;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic int wrap_shift(int afb);
      int j;
      j = 0;
      for (int k = 0; k < 8; k++) begin
         if (((64'd360 << afb) << k) < 64'd131072) begin
            j = k + 1;
         end
      end
      return j;
   endfunction

   function automatic logic signed [V_W-1:0] mul_q30(logic signed [V_W-1:0] a,
                                                     logic signed [V_W-1:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sh2000_0000;
      return p[61:30];
   endfunction

   function automatic logic signed [OUT_W-1:0] to_out(logic signed [33:0] v, int ofb);
      logic signed [34:0] t;
      logic signed [34:0] q;
      logic signed [34:0] hi;
      logic signed [34:0] lo;
      t = 35'(v) + (35'sd1 <<< (VEC_FRAC - 1 - ofb));
      q = t >>> (VEC_FRAC - ofb);
      hi = (ofb >= 15) ? 35'sd32767 : (35'sd1 <<< ofb) - 35'sd1;
      lo = (ofb >= 15) ? -35'sd32768 : -(35'sd1 <<< ofb);
      if (q > hi) begin
         q = hi;
      end
      if (q < lo) begin
         q = lo;
      end
      return q[OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/eab_reduce.sv
// Two-stage angle reduction modulo 360 degrees and fold into the CORDIC range.
`default_nettype none
module eab_reduce
   import eab_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic signed [ANGLE_W-1:0] raw_in,
   output logic signed [Z_W-1:0]          z_out,
   output logic                           neg_out
);

   localparam longint FULL = 64'd360 << ANGLE_FRAC_BITS;
   localparam longint HALF = 64'd180 << ANGLE_FRAC_BITS;
   localparam longint QUAR = 64'd90 << ANGLE_FRAC_BITS;
   localparam int J = wrap_shift(ANGLE_FRAC_BITS);
   localparam longint TOP = FULL << J;
   localparam int VW = $clog2(TOP) + 2;
   localparam int RW = $clog2(FULL) + 1;

   logic [VW-1:0] v;
   logic [RW-1:0] r_in, r_ff;
   logic signed [RW:0] s;
   logic signed [Z_W-1:0] z_in, z_ff;
   logic neg_in, neg_ff;

   always_comb begin
      v = VW'(TOP) + VW'(raw_in);
      for (int k = J; k >= 0; k--) begin
         if (v >= VW'(FULL << k)) begin
            v = v - VW'(FULL << k);
         end
      end
      r_in = RW'(v);
   end

   always_comb begin
      s = $signed({1'b0, r_ff});
      neg_in = 1'b0;
      if (s >= (RW+1)'(HALF)) begin
         s = s - (RW+1)'(FULL);
      end
      if (s > (RW+1)'(QUAR)) begin
         s = (RW+1)'(HALF) - s;
         neg_in = 1'b1;
      end else if (s < -((RW+1)'(QUAR))) begin
         s = -((RW+1)'(HALF)) - s;
         neg_in = 1'b1;
      end
      z_in = Z_W'(s) <<< (DEG_FRAC - ANGLE_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         z_ff <= z_in;
         neg_ff <= neg_in;
      end
   end

   assign z_out = z_ff;
   assign neg_out = neg_ff;

endmodule
`default_nettype wire

FILE: rtl/core/eab_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine, one stage per iteration.
`default_nettype none
module eab_cordic
   import eab_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [Z_W-1:0] z_in,
   input  wire logic                  neg_in,
   output logic signed [V_W-1:0]      sin_out,
   output logic signed [V_W-1:0]      cos_out
);

   logic signed [V_W-1:0] x_ff [CORDIC_STAGES];
   logic signed [V_W-1:0] y_ff [CORDIC_STAGES];
   logic signed [Z_W-1:0] z_ff [CORDIC_STAGES];
   logic neg_ff [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [V_W-1:0] xp, yp, x_in, y_in;
      logic signed [Z_W-1:0] zp, z_next;
      logic np;
      if (i == 0) begin : g_first
         assign xp = CORDIC_GAIN_INV;
         assign yp = '0;
         assign zp = z_in;
         assign np = neg_in;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign np = neg_ff[i-1];
      end
      always_comb begin
         if (zp >= 0) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_next = zp - atan_deg(i);
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_next = zp + atan_deg(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_next;
            neg_ff[i] <= np;
         end
      end
   end

   assign sin_out = y_ff[CORDIC_STAGES-1];
   assign cos_out = neg_ff[CORDIC_STAGES-1] ? -x_ff[CORDIC_STAGES-1] : x_ff[CORDIC_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/core/eab_combine.sv
// Three-stage product, sum, rounding and saturation of the nine basis components.
`default_nettype none
module eab_combine
   import eab_pkg::*;
#(
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [V_W-1:0] sp,
   input  wire logic signed [V_W-1:0] cp,
   input  wire logic signed [V_W-1:0] sy,
   input  wire logic signed [V_W-1:0] cy,
   input  wire logic signed [V_W-1:0] sr,
   input  wire logic signed [V_W-1:0] cr,
   output logic signed [OUT_W-1:0]    o_fwd_x,
   output logic signed [OUT_W-1:0]    o_fwd_y,
   output logic signed [OUT_W-1:0]    o_fwd_z,
   output logic signed [OUT_W-1:0]    o_rgt_x,
   output logic signed [OUT_W-1:0]    o_rgt_y,
   output logic signed [OUT_W-1:0]    o_rgt_z,
   output logic signed [OUT_W-1:0]    o_up_x,
   output logic signed [OUT_W-1:0]    o_up_y,
   output logic signed [OUT_W-1:0]    o_up_z
);

   logic signed [V_W-1:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, nsp_ff, srcp_ff, crcp_ff;
   logic signed [V_W-1:0] crsy_ff, crcy_ff, srsy_ff, srcy_ff, cy_ff, sy_ff;
   logic signed [V_W-1:0] a_cpcy_ff, a_cpsy_ff, a_nsp_ff, a_srcp_ff, a_crcp_ff;
   logic signed [V_W-1:0] a_crsy_ff, a_crcy_ff, a_srsy_ff, a_srcy_ff;
   logic signed [V_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [OUT_W-1:0] o_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         srsp_ff <= mul_q30(sr, sp);
         crsp_ff <= mul_q30(cr, sp);
         cpcy_ff <= mul_q30(cp, cy);
         cpsy_ff <= mul_q30(cp, sy);
         nsp_ff <= -sp;
         srcp_ff <= mul_q30(sr, cp);
         crcp_ff <= mul_q30(cr, cp);
         crsy_ff <= mul_q30(cr, sy);
         crcy_ff <= mul_q30(cr, cy);
         srsy_ff <= mul_q30(sr, sy);
         srcy_ff <= mul_q30(sr, cy);
         cy_ff <= cy;
         sy_ff <= sy;

         t1_ff <= mul_q30(srsp_ff, cy_ff);
         t2_ff <= mul_q30(srsp_ff, sy_ff);
         t3_ff <= mul_q30(crsp_ff, cy_ff);
         t4_ff <= mul_q30(crsp_ff, sy_ff);
         a_cpcy_ff <= cpcy_ff;
         a_cpsy_ff <= cpsy_ff;
         a_nsp_ff <= nsp_ff;
         a_srcp_ff <= srcp_ff;
         a_crcp_ff <= crcp_ff;
         a_crsy_ff <= crsy_ff;
         a_crcy_ff <= crcy_ff;
         a_srsy_ff <= srsy_ff;
         a_srcy_ff <= srcy_ff;

         o_ff[0] <= to_out(34'(a_cpcy_ff), OUT_FRAC_BITS);
         o_ff[1] <= to_out(34'(a_cpsy_ff), OUT_FRAC_BITS);
         o_ff[2] <= to_out(34'(a_nsp_ff), OUT_FRAC_BITS);
         o_ff[3] <= to_out(34'(a_crsy_ff) - 34'(t1_ff), OUT_FRAC_BITS);
         o_ff[4] <= to_out(-34'(t2_ff) - 34'(a_crcy_ff), OUT_FRAC_BITS);
         o_ff[5] <= to_out(-34'(a_srcp_ff), OUT_FRAC_BITS);
         o_ff[6] <= to_out(34'(t3_ff) + 34'(a_srsy_ff), OUT_FRAC_BITS);
         o_ff[7] <= to_out(34'(t4_ff) - 34'(a_srcy_ff), OUT_FRAC_BITS);
         o_ff[8] <= to_out(34'(a_crcp_ff), OUT_FRAC_BITS);
      end
   end

   assign o_fwd_x = o_ff[0];
   assign o_fwd_y = o_ff[1];
   assign o_fwd_z = o_ff[2];
   assign o_rgt_x = o_ff[3];
   assign o_rgt_y = o_ff[4];
   assign o_rgt_z = o_ff[5];
   assign o_up_x = o_ff[6];
   assign o_up_y = o_ff[7];
   assign o_up_z = o_ff[8];

endmodule
`default_nettype wire

FILE: rtl/core/euler_angles_to_basis_vectors_top.sv
// Top level: Euler angles in degrees to forward, right and up unit vectors.
// The request channel takes pitch, yaw and roll in signed fixed-point degrees.
// The response channel returns the nine Q1.15 components of the three vectors.
// Both channels use valid and stall; a transfer happens when valid is high
// and stall is low at a rising clock edge.
// The pipeline takes one request per cycle while no response is stalled and returns one response per request.
// The pipeline stages are angle reduction, the CORDIC iterations, two
// multiplier stages and one rounding stage.
// Throughput is one request per cycle, set by the fully pipelined datapath, unless a stalled response holds it.
// When the receiver stalls a waiting response, the whole pipeline holds and
// req_stall is raised in the same cycle, so nothing is lost or repeated.
// A synchronous reset clears all valid bits; no response follows until a new
// request is accepted.
`default_nettype none
module euler_angles_to_basis_vectors_top
   import eab_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [ANGLE_W-1:0] req_pitch_deg,
   input  wire logic signed [ANGLE_W-1:0] req_yaw_deg,
   input  wire logic signed [ANGLE_W-1:0] req_roll_deg,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_fwd_x,
   output logic signed [OUT_W-1:0]        rsp_fwd_y,
   output logic signed [OUT_W-1:0]        rsp_fwd_z,
   output logic signed [OUT_W-1:0]        rsp_rgt_x,
   output logic signed [OUT_W-1:0]        rsp_rgt_y,
   output logic signed [OUT_W-1:0]        rsp_rgt_z,
   output logic signed [OUT_W-1:0]        rsp_up_x,
   output logic signed [OUT_W-1:0]        rsp_up_y,
   output logic signed [OUT_W-1:0]        rsp_up_z
);

   localparam int LAT = CORDIC_STAGES + 5;

   logic en;
   logic [LAT-1:0] vld_ff;
   logic signed [Z_W-1:0] zp, zy, zr;
   logic np, ny, nr;
   logic signed [V_W-1:0] sp, cp, sy, cy, sr, cr;

   assign en = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   eab_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_p (
      .clock(clock), .en(en), .raw_in(req_pitch_deg), .z_out(zp), .neg_out(np));
   eab_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_y (
      .clock(clock), .en(en), .raw_in(req_yaw_deg), .z_out(zy), .neg_out(ny));
   eab_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_r (
      .clock(clock), .en(en), .raw_in(req_roll_deg), .z_out(zr), .neg_out(nr));

   eab_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_p (
      .clock(clock), .en(en), .z_in(zp), .neg_in(np), .sin_out(sp), .cos_out(cp));
   eab_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_y (
      .clock(clock), .en(en), .z_in(zy), .neg_in(ny), .sin_out(sy), .cos_out(cy));
   eab_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_r (
      .clock(clock), .en(en), .z_in(zr), .neg_in(nr), .sin_out(sr), .cos_out(cr));

   eab_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
      .clock(clock), .en(en),
      .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .o_fwd_x(rsp_fwd_x), .o_fwd_y(rsp_fwd_y), .o_fwd_z(rsp_fwd_z),
      .o_rgt_x(rsp_rgt_x), .o_rgt_y(rsp_rgt_y), .o_rgt_z(rsp_rgt_z),
      .o_up_x(rsp_up_x), .o_up_y(rsp_up_y), .o_up_z(rsp_up_z));

endmodule
`default_nettype wire
